// ===== sv/clt_pkg.sv =====
// shared constants and codes for the console line tagger
`default_nettype none

package clt_pkg;

  localparam int LINE_LENGTH_DEF = 32;
  localparam int NAME_BYTES      = 8;

  localparam int ACTION_W = 2;
  localparam int OFFSET_W = 12;
  localparam int BYTE_W   = 8;
  localparam int NAME_W   = NAME_BYTES * BYTE_W;
  localparam int NLEN_W   = 4;

  localparam logic [ACTION_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_FLUSH = 2'd2;

  localparam logic [OFFSET_W-1:0] DATA_OFFSET = 12'h000;
  localparam logic [OFFSET_W-1:0] FLAG_OFFSET = 12'h018;
  localparam logic [BYTE_W-1:0]   FLAG_VALUE  = 8'h10;

  localparam logic [BYTE_W-1:0] CHAR_NL     = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_LBRACK = 8'h5b;
  localparam logic [BYTE_W-1:0] CHAR_RBRACK = 8'h5d;
  localparam logic [BYTE_W-1:0] CHAR_SPACE  = 8'h20;

  localparam logic CFG_NAME_TEXT   = 1'b0;
  localparam logic CFG_NAME_LENGTH = 1'b1;

endpackage

`default_nettype wire

// ===== sv/clt_if.sv =====
// valid/ready channels for register accesses and console results
`default_nettype none

interface clt_cmd_if import clt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [OFFSET_W-1:0] reg_offset;
  logic [BYTE_W-1:0]   write_data;

  modport source (output valid, action, reg_offset, write_data, input ready);
  modport sink   (input valid, action, reg_offset, write_data, output ready);
endinterface

interface clt_rsp_if import clt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] read_data;
  logic              char_valid;
  logic [BYTE_W-1:0] out_char;
  logic              last;

  modport source (output valid, read_data, char_valid, out_char, last, input ready);
  modport sink   (input valid, read_data, char_valid, out_char, last, output ready);
endinterface

`default_nettype wire

// ===== sv/clt_ram.sv =====
// generic single-write, single-read ram with registered read data
`default_nettype none

module clt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 31
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/console_line_tagger_top.sv =====
// console line tagger: uart data window, line store and tagged line emitter
// results: reads, buffered writes, empty flushes and other accesses give one result,
//   registered the cycle after the item is taken; a line emit then gives one byte per
//   cycle while the output is not stalled: min(name_length, 8)+3 prefix bytes (when a
//   line starts), the stored bytes, then a newline if a newline byte triggered it
// items: a new item is taken only while idle, so none during an emit; the single
//   store read port walks the line one byte a cycle while the output is not stalled
// reset: control state, fill count and config clear, line starts; store is not cleared
`default_nettype none

module console_line_tagger_top import clt_pkg::*; #(
  parameter int LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_write,
  input  wire logic              cfg_index,
  input  wire logic [NAME_W-1:0] cfg_data,
  clt_cmd_if.sink                cmd,
  clt_rsp_if.source              rsp
);

  localparam int STORE_DEPTH = LINE_LENGTH - 1;
  localparam int FILL_W      = $clog2(LINE_LENGTH);
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int POS_W       = (FILL_W > 4) ? FILL_W : 4;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_PREFIX  = 3'd1;
  localparam logic [2:0] S_STORE   = 3'd2;
  localparam logic [2:0] S_NEWLINE = 3'd3;

  logic [2:0]        state, state_next;
  logic [POS_W-1:0]  pos, pos_next;
  logic [FILL_W-1:0] fill_count, fill_count_next;
  logic              line_starting, line_starting_next;
  logic [BYTE_W-1:0] held_byte;
  logic              held_nl;
  logic              held_wr;
  logic [NAME_W-1:0] name_text;
  logic [NLEN_W-1:0] name_length;

  logic              out_valid, out_valid_next;
  logic [BYTE_W-1:0] out_read_data, out_read_data_next;
  logic              out_char_valid, out_char_valid_next;
  logic [BYTE_W-1:0] out_char, out_char_next;
  logic              out_last, out_last_next;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [BYTE_W-1:0] wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  logic              slot_free;
  logic              accept;
  logic              is_data_wr;
  logic              is_nl;
  logic              store_full;
  logic              trig;
  logic              do_flush;
  logic [NLEN_W-1:0] name_len_sat;
  logic [POS_W-1:0]  prefix_end;
  logic [POS_W-1:0]  pos_m1;
  logic [BYTE_W-1:0] prefix_char;
  logic [FILL_W-1:0] fill_m1;
  logic              store_end;

  clt_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign slot_free = !out_valid || rsp.ready;
  assign cmd.ready = (state == S_IDLE) && slot_free;
  assign accept    = cmd.valid && cmd.ready;

  assign is_data_wr = (cmd.action == ACT_WRITE) && (cmd.reg_offset == DATA_OFFSET);
  assign is_nl      = (cmd.write_data == CHAR_NL);
  assign store_full = (fill_count == FILL_W'(STORE_DEPTH));
  assign trig       = is_data_wr && (is_nl || store_full);
  assign do_flush   = (cmd.action == ACT_FLUSH) && (fill_count != '0);

  assign name_len_sat = (name_length > NLEN_W'(NAME_BYTES)) ? NLEN_W'(NAME_BYTES)
                                                            : name_length;
  // prefix positions: bracket, name bytes, bracket, space
  assign prefix_end = POS_W'(name_len_sat) + POS_W'(2);
  assign pos_m1     = pos - POS_W'(1);

  always_comb begin
    if (pos == '0) begin
      prefix_char = CHAR_LBRACK;
    end else if (pos == prefix_end) begin
      prefix_char = CHAR_SPACE;
    end else if (pos == prefix_end - POS_W'(1)) begin
      prefix_char = CHAR_RBRACK;
    end else begin
      prefix_char = name_text[{pos_m1[2:0], 3'b000} +: BYTE_W];
    end
  end

  assign fill_m1   = fill_count - FILL_W'(1);
  assign store_end = (pos == POS_W'(fill_m1));

  always_comb begin
    state_next          = state;
    pos_next            = pos;
    fill_count_next     = fill_count;
    line_starting_next  = line_starting;
    out_valid_next      = rsp.ready ? 1'b0 : out_valid;
    out_read_data_next  = out_read_data;
    out_char_valid_next = out_char_valid;
    out_char_next       = out_char;
    out_last_next       = out_last;
    wr_en               = 1'b0;
    wr_addr             = fill_count[ADDR_W-1:0];
    wr_data             = cmd.write_data;
    rd_en               = 1'b0;
    rd_addr             = '0;

    case (state)
      S_IDLE: begin
        if (accept) begin
          pos_next = '0;
          if (trig || do_flush) begin
            if (line_starting) begin
              state_next = S_PREFIX;
            end else if (fill_count != '0) begin
              rd_en      = 1'b1;
              state_next = S_STORE;
            end else begin
              state_next = S_NEWLINE;
            end
          end else begin
            // single result carrying no console byte
            out_valid_next      = 1'b1;
            out_read_data_next  = ((cmd.action == ACT_READ) &&
                                   (cmd.reg_offset == FLAG_OFFSET)) ? FLAG_VALUE : '0;
            out_char_valid_next = 1'b0;
            out_char_next       = '0;
            out_last_next       = 1'b1;
            if (is_data_wr) begin
              wr_en           = 1'b1;
              fill_count_next = fill_count + FILL_W'(1);
            end
          end
        end
      end
      S_PREFIX: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          out_read_data_next  = '0;
          out_char_valid_next = 1'b1;
          out_char_next       = prefix_char;
          out_last_next       = 1'b0;
          pos_next            = pos + POS_W'(1);
          if (pos == prefix_end) begin
            line_starting_next = 1'b0;
            pos_next           = '0;
            if (fill_count != '0) begin
              rd_en      = 1'b1;
              state_next = S_STORE;
            end else begin
              state_next = S_NEWLINE;
            end
          end
        end
      end
      S_STORE: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          out_read_data_next  = '0;
          out_char_valid_next = 1'b1;
          out_char_next       = rd_data;
          out_last_next       = store_end && !held_nl;
          if (!store_end) begin
            rd_en    = 1'b1;
            pos_next = pos + POS_W'(1);
            rd_addr  = ADDR_W'(pos + POS_W'(1));
          end else if (held_nl) begin
            fill_count_next = '0;
            state_next      = S_NEWLINE;
          end else if (held_wr) begin
            // overflow: the triggering byte opens the next line
            wr_en           = 1'b1;
            wr_addr         = '0;
            wr_data         = held_byte;
            fill_count_next = FILL_W'(1);
            state_next      = S_IDLE;
          end else begin
            fill_count_next = '0;
            state_next      = S_IDLE;
          end
        end
      end
      S_NEWLINE: begin
        if (slot_free) begin
          out_valid_next      = 1'b1;
          out_read_data_next  = '0;
          out_char_valid_next = 1'b1;
          out_char_next       = CHAR_NL;
          out_last_next       = 1'b1;
          line_starting_next  = 1'b1;
          fill_count_next     = '0;
          state_next          = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      pos           <= '0;
      fill_count    <= '0;
      line_starting <= 1'b1;
      name_text     <= '0;
      name_length   <= '0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      pos           <= pos_next;
      fill_count    <= fill_count_next;
      line_starting <= line_starting_next;
      out_valid     <= out_valid_next;
      if (cfg_write) begin
        case (cfg_index)
          CFG_NAME_TEXT:   name_text   <= cfg_data;
          CFG_NAME_LENGTH: name_length <= cfg_data[NLEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_read_data  <= out_read_data_next;
    out_char_valid <= out_char_valid_next;
    out_char       <= out_char_next;
    out_last       <= out_last_next;
    if (accept) begin
      held_byte <= cmd.write_data;
      held_nl   <= is_data_wr && is_nl;
      held_wr   <= is_data_wr;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_read_data;
  assign rsp.char_valid = out_char_valid;
  assign rsp.out_char   = out_char;
  assign rsp.last       = out_last;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_W'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) && out_valid |-> out_last)
    else $error("sequencer idle with a non-final result pending");

  a_no_char_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_char_valid |-> out_last && (out_char == '0))
    else $error("result without console byte is not a lone final result");

  a_prefix_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(line_starting) |-> $past(state) == S_PREFIX)
    else $error("line start cleared outside the prefix");

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking bench for the console line tagger: directed accesses, then random console traffic
`timescale 1ns / 1ps

module tb_top;
  import clt_pkg::*;

  localparam int STORE_DEPTH = LINE_LENGTH_DEF - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_ITEMS = 60;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [BYTE_W-1:0] read_data;
    logic              char_valid;
    logic [BYTE_W-1:0] out_char;
    logic              last;
  } console_beat_t;

  // fixed rows carry their single no-char result typed in; they leave the line state alone
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [OFFSET_W-1:0] reg_offset;
    logic [BYTE_W-1:0]   data;
    logic                fixed;
    logic [BYTE_W-1:0]   read_val;
  } access_row_t;

  localparam access_row_t DIRECTED_ROWS[20] = '{
    '{ACT_READ,   FLAG_OFFSET, 8'h00,       1'b1, FLAG_VALUE},
    '{ACT_READ,   DATA_OFFSET, 8'h00,       1'b1, 8'h00},
    '{ACT_READ,   12'hfff,     8'hff,       1'b1, 8'h00},
    '{ACT_READ,   12'h019,     8'h00,       1'b1, 8'h00},
    '{ACT_WRITE,  12'hfff,     8'hff,       1'b1, 8'h00},
    '{ACT_WRITE,  FLAG_OFFSET, CHAR_NL,     1'b1, 8'h00},
    '{ACT_UNUSED, FLAG_OFFSET, 8'h00,       1'b1, 8'h00},
    '{ACT_FLUSH,  DATA_OFFSET, 8'h00,       1'b1, 8'h00},
    '{ACT_WRITE,  DATA_OFFSET, 8'h41,       1'b0, 8'h00},
    '{ACT_WRITE,  DATA_OFFSET, 8'h00,       1'b0, 8'h00},
    '{ACT_WRITE,  DATA_OFFSET, 8'hff,       1'b0, 8'h00},
    '{ACT_FLUSH,  DATA_OFFSET, 8'h00,       1'b0, 8'h00},
    '{ACT_FLUSH,  12'h7ff,     8'h00,       1'b1, 8'h00},
    '{ACT_WRITE,  DATA_OFFSET, CHAR_NL,     1'b0, 8'h00},
    '{ACT_WRITE,  DATA_OFFSET, CHAR_NL,     1'b0, 8'h00},
    '{ACT_WRITE,  DATA_OFFSET, 8'h7e,       1'b0, 8'h00},
    '{ACT_READ,   FLAG_OFFSET, 8'h55,       1'b1, FLAG_VALUE},
    '{ACT_WRITE,  12'h001,     8'h55,       1'b1, 8'h00},
    '{ACT_WRITE,  DATA_OFFSET, CHAR_NL,     1'b0, 8'h00},
    '{ACT_UNUSED, DATA_OFFSET, 8'haa,       1'b1, 8'h00}
  };

  logic              clk = 1'b0;
  logic              rst;
  logic              cfg_write;
  logic              cfg_index;
  logic [NAME_W-1:0] cfg_data;

  clt_cmd_if cmd_ch ();
  clt_rsp_if rsp_ch ();

  console_line_tagger_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the line state and name registers
  logic [NAME_W-1:0] name_bytes;
  logic [NLEN_W-1:0] name_len;
  logic [BYTE_W-1:0] line_buf [STORE_DEPTH];
  int                line_fill;
  bit                line_fresh;

  console_beat_t awaited_beats[$];
  int            mismatches;
  int            items_sent;
  bit            tx_calm;
  bit            rx_calm;
  int            rx_hold;
  console_beat_t got_beat;
  console_beat_t want_beat;

  task automatic push_char(input logic [BYTE_W-1:0] ch);
    console_beat_t beat;
    beat = '{read_data: '0, char_valid: 1'b1, out_char: ch, last: 1'b0};
    awaited_beats.push_back(beat);
  endtask

  task automatic push_prefix();
    int n;
    if (line_fresh) begin
      n = (name_len > NAME_BYTES) ? NAME_BYTES : int'(name_len);
      push_char(CHAR_LBRACK);
      for (int i = 0; i < n; i++) push_char(name_bytes[8*i +: 8]);
      push_char(CHAR_RBRACK);
      push_char(CHAR_SPACE);
      line_fresh = 1'b0;
    end
  endtask

  task automatic push_line();
    for (int i = 0; i < line_fill; i++) push_char(line_buf[i]);
    line_fill = 0;
  endtask

  task automatic store_byte(input logic [BYTE_W-1:0] c);
    if (c == CHAR_NL || line_fill >= STORE_DEPTH) begin
      push_prefix();
      push_line();
      if (c == CHAR_NL) begin
        push_char(CHAR_NL);
        line_fresh = 1'b1;
      end else begin
        // overflow: the byte that did not fit opens the next store
        line_buf[0] = c;
        line_fill = 1;
      end
    end else begin
      line_buf[line_fill] = c;
      line_fill++;
    end
  endtask

  task automatic predict_console(input logic [ACTION_W-1:0] act,
                                 input logic [OFFSET_W-1:0] ofs,
                                 input logic [BYTE_W-1:0] dat);
    int base;
    logic [BYTE_W-1:0] rd;
    console_beat_t beat;
    base = awaited_beats.size();
    rd = '0;
    case (act)
      ACT_READ:  rd = (ofs == FLAG_OFFSET) ? FLAG_VALUE : '0;
      ACT_WRITE: if (ofs == DATA_OFFSET) store_byte(dat);
      ACT_FLUSH: begin
        if (line_fill > 0) begin
          push_prefix();
          push_line();
        end
      end
      default: ;
    endcase
    if (awaited_beats.size() == base) begin
      beat = '{read_data: rd, char_valid: 1'b0, out_char: '0, last: 1'b0};
      awaited_beats.push_back(beat);
    end
    beat = awaited_beats.pop_back();
    beat.last = 1'b1;
    awaited_beats.push_back(beat);
  endtask

  // entered and left at a falling edge; valid stays high into a zero gap
  task automatic send_access(input logic [ACTION_W-1:0] act,
                             input logic [OFFSET_W-1:0] ofs,
                             input logic [BYTE_W-1:0] dat,
                             input logic fixed,
                             input logic [BYTE_W-1:0] fixed_rd);
    int gap;
    console_beat_t beat;
    gap = tx_calm ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd_ch.action     <= act;
    cmd_ch.reg_offset <= ofs;
    cmd_ch.write_data <= dat;
    cmd_ch.valid      <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    if (fixed) begin
      beat = '{read_data: fixed_rd, char_valid: 1'b0, out_char: '0, last: 1'b1};
      awaited_beats.push_back(beat);
    end else begin
      predict_console(act, ofs, dat);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained(input int settle);
    cmd_ch.valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  // both registers in back-to-back cycles so the write enable is raised only once
  task automatic load_name(input logic [NAME_W-1:0] text, input logic [NLEN_W-1:0] len);
    cfg_write <= 1'b1;
    cfg_index <= CFG_NAME_TEXT;
    cfg_data  <= text;
    @(negedge clk);
    cfg_index <= CFG_NAME_LENGTH;
    cfg_data  <= NAME_W'(len);
    @(negedge clk);
    cfg_write <= 1'b0;
    name_bytes = text;
    name_len   = len;
  endtask

  function automatic logic [BYTE_W-1:0] line_char();
    if ($urandom_range(0, 7) == 0) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($urandom_range(8'h20, 8'h7e));
  endfunction

  task automatic random_traffic(input int count);
    int stop_at;
    int kind;
    int len;
    int ending;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 15) == 0) wait_drained(0);
      if (kind < 70) begin
        // mostly short lines, now and then one long enough to overflow the store
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 75) : $urandom_range(0, 20);
        for (int i = 0; i < len; i++) send_access(ACT_WRITE, DATA_OFFSET, line_char(), 1'b0, '0);
        ending = $urandom_range(0, 19);
        if (ending < 14) send_access(ACT_WRITE, DATA_OFFSET, CHAR_NL, 1'b0, '0);
        else if (ending < 17) send_access(ACT_FLUSH, DATA_OFFSET, '0, 1'b0, '0);
      end else if (kind < 80) begin
        send_access(ACT_READ,
                    $urandom_range(0, 1) ? FLAG_OFFSET : OFFSET_W'($urandom_range(0, 4095)),
                    BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 88) begin
        send_access(ACT_WRITE, OFFSET_W'($urandom_range(1, 4095)),
                    BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
      end else if (kind < 94) begin
        send_access(ACT_FLUSH, OFFSET_W'($urandom_range(0, 4095)),
                    BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
      end else begin
        send_access(ACT_UNUSED, OFFSET_W'($urandom_range(0, 4095)),
                    BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
      end
    end
  endtask

  // result check at the rising edge, ready driven at the falling edge
  always begin
    @(posedge clk);
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got_beat = '{read_data: rsp_ch.read_data, char_valid: rsp_ch.char_valid,
                   out_char: rsp_ch.out_char, last: rsp_ch.last};
      if (awaited_beats.size() == 0) begin
        $error("result with nothing awaited: char_valid %0b out_char %h last %0b",
               got_beat.char_valid, got_beat.out_char, got_beat.last);
        mismatches++;
      end else begin
        want_beat = awaited_beats.pop_front();
        if (got_beat.read_data !== want_beat.read_data) begin
          $error("read_data: expected %h, got %h", want_beat.read_data, got_beat.read_data);
          mismatches++;
        end
        if (got_beat.char_valid !== want_beat.char_valid) begin
          $error("char_valid: expected %0b, got %0b", want_beat.char_valid,
                 got_beat.char_valid);
          mismatches++;
        end
        if (got_beat.out_char !== want_beat.out_char) begin
          $error("out_char: expected %h, got %h", want_beat.out_char, got_beat.out_char);
          mismatches++;
        end
        if (got_beat.last !== want_beat.last) begin
          $error("last: expected %0b, got %0b", want_beat.last, got_beat.last);
          mismatches++;
        end
      end
      rx_hold = rx_calm ? 0 : $urandom_range(0, 12);
    end
    @(negedge clk);
    if (rx_hold > 0) begin
      rsp_ch.ready <= 1'b0;
      rx_hold--;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // ends the run when neither channel has moved an item for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst               = 1'b1;
    cfg_write         = 1'b0;
    cfg_index         = CFG_NAME_TEXT;
    cfg_data          = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.action     = ACT_READ;
    cmd_ch.reg_offset = '0;
    cmd_ch.write_data = '0;
    rsp_ch.ready      = 1'b0;
    rx_hold           = 0;
    mismatches        = 0;
    items_sent        = 0;
    tx_calm           = 1'b0;
    rx_calm           = 1'b0;
    name_bytes        = '0;
    name_len          = '0;
    line_fill         = 0;
    line_fresh        = 1'b1;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset values of the name registers: empty prefix "[] "
    foreach (DIRECTED_ROWS[r]) begin
      send_access(DIRECTED_ROWS[r].action, DIRECTED_ROWS[r].reg_offset,
                  DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].read_val);
    end

    for (int p = 0; p < 5; p++) begin
      wait_drained(8);
      tx_calm = (p == 1 || p == 3);
      rx_calm = (p == 2 || p == 3);
      case (p)
        0: load_name({$urandom, $urandom}, 4'd8);
        1: load_name({NAME_W{1'b1}}, 4'd15);
        2: load_name('0, 4'd8);
        3: load_name({$urandom, $urandom}, NLEN_W'($urandom_range(0, 15)));
        default: load_name({$urandom, $urandom}, 4'd0);
      endcase
      random_traffic(PHASE_ITEMS);
    end

    wait_drained(50);
    if (mismatches == 0 && awaited_beats.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/clt_pkg.sv
sv/clt_if.sv
sv/clt_ram.sv
sv/console_line_tagger_top.sv
verif/tb_top.sv
